### hdl/tmtw_pkg.sv
// tmtw_pkg: shared constants, command type and address helper for the
// text-mode terminal writer. No dependencies.
`default_nettype none
package tmtw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int AW      = $clog2(CELLS);

  // field widths
  localparam int RW  = 5;
  localparam int CLW = 7;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_COLOR  = 8'd10;

  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [CLW-1:0] COL_LAST = CLW'(COLUMNS - 1);

  localparam logic [AW-1:0] CELL_LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST   = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] BLANK_FIRST = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);

  // opcodes
  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_NL    = 3'd1;
  localparam logic [2:0] OP_BS    = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_SCROLL
  } cmd_kind_t;

  // one classified item as handed from front to back
  typedef struct packed {
    cmd_kind_t       kind;
    logic [AW-1:0]   addr;
    logic [15:0]     data;
    logic [RW-1:0]   row;
    logic [CLW-1:0]  col;
    logic            scroll;
    logic            rerr;
  } cmd_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CLW-1:0] c);
    cell_addr = AW'(AW'(r) * ROW_STRIDE + AW'(c));
  endfunction

endpackage
`default_nettype wire

### hdl/text_mode_terminal_writer_unit.sv
// text_mode_terminal_writer_unit: top level joining front, queue and back.
// Depends on tmtw_pkg, tmtw_front, tmtw_queue, tmtw_back.
//
//  channel   handshake            payload
//  input     start / busy         opcode char_code cell_color col_x row_y
//  result    done (strobe)        cursor_row cursor_col read_char read_color
//                                 did_scroll range_error
//  config    text_color_we        text_color_wdata
//
// Writes, cursor moves and error cases complete in the back end's idle state;
// reads pass through a read state (registered memory read port); a scroll
// moves one cell per cycle over the single write port.
// After reset a clearing pass blanks the store,
// with busy high throughout. busy also rises when the two-entry queue is full.
// Each result is shown for one cycle on done; the receiver cannot stall.
`default_nettype none
module text_mode_terminal_writer_unit import tmtw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] cell_color,
  input  wire logic [6:0] col_x,
  input  wire logic [4:0] row_y,
  input  wire logic       text_color_we,
  input  wire logic [7:0] text_color_wdata,
  output logic            done,
  output logic [4:0]      cursor_row,
  output logic [6:0]      cursor_col,
  output logic [7:0]      read_char,
  output logic [7:0]      read_color,
  output logic            did_scroll,
  output logic            range_error
);

  logic [7:0] text_color;
  logic       accept, pop, empty, full, clearing;
  cmd_t       front_cmd, head;

  assign busy   = full || clearing;
  assign accept = start && !busy;

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (text_color_we) begin
      text_color <= text_color_wdata;
    end
  end

  tmtw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (opcode),
    .char_code  (char_code),
    .cell_color (cell_color),
    .col_x      (col_x),
    .row_y      (row_y),
    .text_color (text_color),
    .cmd        (front_cmd)
  );

  tmtw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  tmtw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .clearing    (clearing),
    .done        (done),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col),
    .read_char   (read_char),
    .read_color  (read_color),
    .did_scroll  (did_scroll),
    .range_error (range_error)
  );

endmodule
`default_nettype wire

### hdl/tmtw_ram.sv
// tmtw_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/tmtw_front.sv
// tmtw_front: accepts items, keeps the cursor and classifies each item
// into a memory command. Depends on tmtw_pkg.
`default_nettype none
module tmtw_front import tmtw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] cell_color,
  input  wire logic [6:0] col_x,
  input  wire logic [4:0] row_y,
  input  wire logic [7:0] text_color,
  output cmd_t            cmd
);

  logic [RW-1:0]  row, row_next;
  logic [CLW-1:0] col, col_next;
  logic           in_screen;

  assign in_screen = (col_x <= COL_LAST) && (row_y <= ROW_LAST);

  // classify the item and work out the next cursor
  always_comb begin
    row_next   = row;
    col_next   = col;
    cmd.kind   = CMD_NONE;
    cmd.addr   = cell_addr(row_y, col_x);
    cmd.data   = {text_color, BLANK_CHAR};
    cmd.scroll = 1'b0;
    cmd.rerr   = 1'b0;
    if ((opcode == OP_NL) || ((opcode == OP_PUT) && (char_code == NEWLINE_CHAR))) begin
      col_next = '0;
      if (row != ROW_LAST) begin
        row_next = row + 1'b1;
      end else begin
        cmd.kind   = CMD_SCROLL;
        cmd.scroll = 1'b1;
      end
    end else if (opcode == OP_PUT) begin
      cmd.kind = CMD_WRITE;
      cmd.addr = cell_addr(row, col);
      cmd.data = {text_color, char_code};
      if (col == COL_LAST) begin
        col_next = '0;
        row_next = (row == ROW_LAST) ? '0 : row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end else if (opcode == OP_BS) begin
      if (col != '0) begin
        col_next = col - 1'b1;
      end else if (row != '0) begin
        col_next = COL_LAST;
        row_next = row - 1'b1;
      end
      cmd.kind = CMD_WRITE;
      cmd.addr = cell_addr(row_next, col_next);
    end else if (opcode == OP_WRITE) begin
      cmd.data = {cell_color, char_code};
      if (in_screen) cmd.kind = CMD_WRITE;
      else cmd.rerr = 1'b1;
    end else if (opcode == OP_READ) begin
      if (in_screen) cmd.kind = CMD_READ;
      else cmd.rerr = 1'b1;
    end
    cmd.row = row_next;
    cmd.col = col_next;
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule
`default_nettype wire

### hdl/tmtw_queue.sv
// tmtw_queue: two-entry command queue between front and back.
// Depends on tmtw_pkg.
`default_nettype none
module tmtw_queue import tmtw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

### hdl/tmtw_back.sv
// tmtw_back: carries out queued commands on the screen store: clearing
// pass, cell writes, reads and row-by-row scroll. Depends on tmtw_pkg, tmtw_ram.
`default_nettype none
module tmtw_back import tmtw_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  cmd_t        head,
  input  wire logic   empty,
  output logic        pop,
  output logic        clearing,
  output logic        done,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [7:0]  read_char,
  output logic [7:0]  read_color,
  output logic        did_scroll,
  output logic        range_error
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK
  } state_t;

  state_t        state;
  cmd_t          cur;
  logic [AW-1:0] cnt;
  logic          copy_valid;
  logic [AW-1:0] copy_addr;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  tmtw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !empty;

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = {RESET_COLOR, BLANK_CHAR};
    raddr = head.addr;
    unique case (state)
      ST_CLEAR: we = 1'b1;
      ST_IDLE: begin
        waddr = head.addr;
        wdata = head.data;
        we    = !empty && (head.kind == CMD_WRITE);
      end
      ST_READ: ;
      ST_COPY: begin
        raddr = cnt + ROW_STRIDE;
        waddr = copy_addr;
        wdata = rdata;
        we    = copy_valid;
      end
      ST_BLANK: begin
        we = 1'b1;
        if (copy_valid) begin
          waddr = copy_addr;
          wdata = rdata;
        end else begin
          wdata = cur.data;
        end
      end
      default: ;
    endcase
  end

  // sequencer with registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      copy_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CELL_LAST) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!empty) begin
            cur <= head;
            if (head.kind == CMD_READ) begin
              state <= ST_READ;
            end else if (head.kind == CMD_SCROLL) begin
              cnt   <= '0;
              state <= ST_COPY;
            end else begin
              done        <= 1'b1;
              cursor_row  <= head.row;
              cursor_col  <= head.col;
              read_char   <= '0;
              read_color  <= '0;
              did_scroll  <= head.scroll;
              range_error <= head.rerr;
            end
          end
        end
        ST_READ: begin
          done        <= 1'b1;
          cursor_row  <= cur.row;
          cursor_col  <= cur.col;
          read_char   <= rdata[7:0];
          read_color  <= rdata[15:8];
          did_scroll  <= 1'b0;
          range_error <= 1'b0;
          state       <= ST_IDLE;
        end
        ST_COPY: begin
          copy_valid <= 1'b1;
          copy_addr  <= cnt;
          if (cnt == COPY_LAST) begin
            cnt   <= BLANK_FIRST;
            state <= ST_BLANK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_BLANK: begin
          copy_valid <= 1'b0;
          if (!copy_valid) begin
            if (cnt == CELL_LAST) begin
              done        <= 1'b1;
              cursor_row  <= cur.row;
              cursor_col  <= cur.col;
              read_char   <= '0;
              read_color  <= '0;
              did_scroll  <= 1'b1;
              range_error <= 1'b0;
              state       <= ST_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop) else $error("pop during clearing pass");
  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    done && did_scroll |-> (cursor_row == ROW_LAST) && (cursor_col == '0))
    else $error("scroll result with bad cursor");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    done |-> cursor_col <= COL_LAST) else $error("cursor column out of range");
  a_copy_only: assert property (@(posedge clk) disable iff (rst)
    copy_valid |-> (state == ST_COPY) || (state == ST_BLANK))
    else $error("pending copy outside scroll");

endmodule
`default_nettype wire
